FILE: hw/rtl/plqm_pkg.sv
// package: widths, event codes and register map of the link quality monitor
`timescale 1ns / 1ps

package plqm_pkg;

	// width of the packet and loss counters
	localparam int CNT_W = 32;
	// width of the reported statistics
	localparam int OUT_W = 32;
	// scale factor for packets per second and per mille
	localparam int SCALE_W = 10;
	localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(1000);
	// forward sequence jumps below this count as loss
	localparam logic [15:0] LOSS_JUMP_LIMIT = 16'd1000;
	// serial divider widths: count times an 11 bit factor over a 33 bit divisor
	localparam int FACTOR_W = 11;
	localparam int DVD_W = CNT_W + FACTOR_W;
	localparam int DVS_W = CNT_W + 1;

	// configuration port
	localparam int APB_AW = 5;
	localparam int APB_DW = 32;

	// register reset values
	localparam logic [7:0]  RST_VERSION   = 8'd1;
	localparam logic [7:0]  RST_BEGIN     = 8'd0;
	localparam logic [7:0]  RST_END       = 8'd1;
	localparam logic [7:0]  RST_CHUNK     = 8'd2;
	localparam logic [7:0]  RST_MSG_BYTES = 8'd224;
	localparam logic [15:0] RST_PERIOD    = 16'd1000;

	typedef enum logic [2:0] {
		REG_VERSION   = 3'd0,
		REG_BEGIN     = 3'd1,
		REG_END       = 3'd2,
		REG_CHUNK     = 3'd3,
		REG_MSG_BYTES = 3'd4,
		REG_PERIOD    = 3'd5
	} reg_index_t;

	typedef enum logic [2:0] {
		EV_CHUNK   = 3'd0,
		EV_BAD     = 3'd1,
		EV_BEGIN   = 3'd2,
		EV_END     = 3'd3,
		EV_NOT_DUE = 3'd4,
		EV_REPORT  = 3'd5
	} event_kind_t;

endpackage

FILE: hw/rtl/plqm_in_if.sv
// interface: packet header and poll channel
`timescale 1ns / 1ps

interface plqm_in_if import plqm_pkg::*;;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  packet_length;
	logic [7:0]  version_byte;
	logic [7:0]  message_type;
	logic [15:0] sequence_req;
	logic [31:0] time_us;
	logic [31:0] time_ms;

	modport source (
		output valid, action, packet_length, version_byte, message_type,
		       sequence_req, time_us, time_ms,
		input  ready
	);
	modport sink (
		input  valid, action, packet_length, version_byte, message_type,
		       sequence_req, time_us, time_ms,
		output ready
	);
endinterface

FILE: hw/rtl/plqm_out_if.sv
// interface: event and statistics report channel
`timescale 1ns / 1ps

interface plqm_out_if import plqm_pkg::*;;
	logic             valid;
	logic             ready;
	logic [2:0]       event_kind;
	logic [OUT_W-1:0] packets_per_second;
	logic [OUT_W-1:0] payload_kbps;
	logic [OUT_W-1:0] window_lost;
	logic [9:0]       loss_per_mille;
	logic [OUT_W-1:0] gap_max_us;
	logic [OUT_W-1:0] received_total;
	logic [OUT_W-1:0] reordered_total;
	logic [OUT_W-1:0] bad_total;
	logic             nothing_arriving;

	modport source (
		output valid, event_kind, packets_per_second, payload_kbps, window_lost,
		       loss_per_mille, gap_max_us, received_total, reordered_total,
		       bad_total, nothing_arriving,
		input  ready
	);
	modport sink (
		input  valid, event_kind, packets_per_second, payload_kbps, window_lost,
		       loss_per_mille, gap_max_us, received_total, reordered_total,
		       bad_total, nothing_arriving,
		output ready
	);
endinterface

FILE: hw/rtl/plqm_sdiv.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module plqm_sdiv import plqm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [STEP_W-1:0] step_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W:0]    trial;
	logic [DVS_W:0]    diff;
	logic              fits;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (start) begin
			step_q <= STEP_W'(DVD_W);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	// dividend shifts out at the top as quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (step_q != '0) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy     = step_q != '0;
	assign quotient = quo_q;

endmodule

FILE: hw/rtl/packet_link_quality_monitor.sv
// top level: packet link quality monitor with serial report arithmetic
`timescale 1ns / 1ps

// Classifies packet headers (bad header, session begin, session end, chunk),
// keeps wrap-safe sequence loss and reorder counts and the longest chunk gap,
// and on a poll at least one report period after the window start emits a
// report and opens a new window. Every accepted item gives exactly one result.
// A packet or a poll that is not yet due is decoded in the execute state; a
// report moves on to the divide state, where the three quotients (packets
// per second, kbps and loss per mille) run on three bit-serial dividers side
// by side, one quotient bit per cycle over the 43 bit dividend. One item is
// handled at a time; the next is accepted while the previous result waits in
// the output register. Registers sit at byte address 4*i on the APB port.
module packet_link_quality_monitor import plqm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	plqm_in_if.sink           item,
	plqm_out_if.source        result
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIV
	} state_t;

	// configuration registers
	logic [7:0]  exp_version_q;
	logic [7:0]  begin_code_q;
	logic [7:0]  end_code_q;
	logic [7:0]  chunk_code_q;
	logic [7:0]  msg_bytes_q;
	logic [15:0] period_q;

	// accepted item
	logic        action_q;
	logic [7:0]  length_q;
	logic [7:0]  version_q;
	logic [7:0]  type_q;
	logic [15:0] seq_q;
	logic [31:0] time_us_q;
	logic [31:0] time_ms_q;

	// monitor state
	state_t           state_q;
	logic [15:0]      next_seq_q;
	logic             session_q;
	logic [CNT_W-1:0] rx_total_q;
	logic [CNT_W-1:0] reorder_q;
	logic [CNT_W-1:0] bad_q;
	logic [31:0]      win_start_q;
	logic [CNT_W-1:0] win_rx_q;
	logic [CNT_W-1:0] win_loss_q;
	logic [31:0]      last_us_q;
	logic [31:0]      max_gap_q;

	// output register
	logic             res_valid_q;
	event_kind_t      ev_q;
	logic [OUT_W-1:0] pps_q;
	logic [OUT_W-1:0] kbps_q;
	logic [OUT_W-1:0] lost_q;
	logic [9:0]       pm_q;
	logic [OUT_W-1:0] gap_out_q;
	logic [OUT_W-1:0] rx_out_q;
	logic [OUT_W-1:0] reorder_out_q;
	logic [OUT_W-1:0] bad_out_q;
	logic             idle_out_q;

	// combinational decode
	logic             cfg_write;
	logic             out_free;
	logic             res_load;
	logic             hdr_ok;
	logic             is_begin;
	logic             is_end;
	logic             is_chunk;
	logic [31:0]      elapsed;
	logic [15:0]      period_eff;
	logic             due;
	logic             div_start;
	logic [15:0]      base_next;
	logic [31:0]      base_last;
	logic [31:0]      base_max;
	logic [CNT_W-1:0] base_rx_total;
	logic [CNT_W-1:0] base_reorder;
	logic [CNT_W-1:0] base_bad;
	logic [CNT_W-1:0] base_win_rx;
	logic [CNT_W-1:0] base_win_loss;
	logic [31:0]      base_win_start;
	logic [31:0]      gap;
	logic [15:0]      jump;
	logic [FACTOR_W-1:0] kbps_factor;
	logic [DVD_W-1:0] pps_dvd;
	logic [DVD_W-1:0] kbps_dvd;
	logic [DVD_W-1:0] pm_dvd;
	logic [DVS_W-1:0] rate_dvs;
	logic [DVS_W-1:0] offered;
	logic [DVD_W-1:0] pps_quo;
	logic [DVD_W-1:0] kbps_quo;
	logic [DVD_W-1:0] pm_quo;
	logic             pps_busy;
	logic             kbps_busy;
	logic             pm_busy;
	logic             div_busy;
	logic [OUT_W-1:0] pps_sat;
	logic [OUT_W-1:0] kbps_sat;

	// configuration writes
	assign cfg_write = psel && penable && pwrite;
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_version_q <= RST_VERSION;
			begin_code_q  <= RST_BEGIN;
			end_code_q    <= RST_END;
			chunk_code_q  <= RST_CHUNK;
			msg_bytes_q   <= RST_MSG_BYTES;
			period_q      <= RST_PERIOD;
		end else if (cfg_write) begin
			case (paddr[APB_AW-1:2])
				REG_VERSION:   exp_version_q <= pwdata[7:0];
				REG_BEGIN:     begin_code_q  <= pwdata[7:0];
				REG_END:       end_code_q    <= pwdata[7:0];
				REG_CHUNK:     chunk_code_q  <= pwdata[7:0];
				REG_MSG_BYTES: msg_bytes_q   <= pwdata[7:0];
				REG_PERIOD:    period_q      <= pwdata[15:0];
				default:       ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[APB_AW-1:2])
			REG_VERSION:   prdata = APB_DW'(exp_version_q);
			REG_BEGIN:     prdata = APB_DW'(begin_code_q);
			REG_END:       prdata = APB_DW'(end_code_q);
			REG_CHUNK:     prdata = APB_DW'(chunk_code_q);
			REG_MSG_BYTES: prdata = APB_DW'(msg_bytes_q);
			REG_PERIOD:    prdata = APB_DW'(period_q);
			default:       prdata = '0;
		endcase
	end

	// capture the accepted item
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			action_q  <= item.action;
			length_q  <= item.packet_length;
			version_q <= item.version_byte;
			type_q    <= item.message_type;
			seq_q     <= item.sequence_req;
			time_us_q <= item.time_us;
			time_ms_q <= item.time_ms;
		end
	end

	// header classification, first match wins
	always_comb begin
		hdr_ok   = (length_q == msg_bytes_q) && (version_q == exp_version_q);
		is_begin = hdr_ok && (type_q == begin_code_q);
		is_end   = hdr_ok && !is_begin && (type_q == end_code_q);
		is_chunk = hdr_ok && !is_begin && !is_end && (type_q == chunk_code_q);
	end

	// a chunk with no session open starts one first
	always_comb begin
		base_next      = session_q ? next_seq_q  : 16'd1;
		base_last      = session_q ? last_us_q   : time_us_q;
		base_max       = session_q ? max_gap_q   : '0;
		base_rx_total  = session_q ? rx_total_q  : '0;
		base_reorder   = session_q ? reorder_q   : '0;
		base_bad       = session_q ? bad_q       : '0;
		base_win_rx    = session_q ? win_rx_q    : '0;
		base_win_loss  = session_q ? win_loss_q  : '0;
		base_win_start = session_q ? win_start_q : time_ms_q;
		gap            = time_us_q - base_last;
		jump           = seq_q - base_next;
	end

	// report due check
	always_comb begin
		elapsed    = time_ms_q - win_start_q;
		period_eff = (period_q == '0) ? 16'd1 : period_q;
		due        = elapsed >= 32'(period_eff);
	end

	assign out_free  = !res_valid_q || result.ready;
	assign div_start = (state_q == S_EXEC) && action_q && due;

	// a finished item loads the output register
	always_comb begin
		res_load = out_free && (((state_q == S_EXEC) && !(action_q && due)) ||
			((state_q == S_DIV) && !div_busy));
	end

	// divider operands
	always_comb begin
		kbps_factor = {msg_bytes_q, 3'b000};
		pps_dvd     = DVD_W'(win_rx_q) * DVD_W'(RATE_SCALE);
		kbps_dvd    = DVD_W'(win_rx_q) * DVD_W'(kbps_factor);
		pm_dvd      = DVD_W'(win_loss_q) * DVD_W'(RATE_SCALE);
		rate_dvs    = DVS_W'(elapsed);
		offered     = DVS_W'(win_rx_q) + DVS_W'(win_loss_q);
	end

	plqm_sdiv u_div_pps (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pps_dvd),
		.divisor  (rate_dvs),
		.busy     (pps_busy),
		.quotient (pps_quo)
	);

	plqm_sdiv u_div_kbps (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (kbps_dvd),
		.divisor  (rate_dvs),
		.busy     (kbps_busy),
		.quotient (kbps_quo)
	);

	plqm_sdiv u_div_pm (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pm_dvd),
		.divisor  (offered),
		.busy     (pm_busy),
		.quotient (pm_quo)
	);

	assign div_busy = pps_busy || kbps_busy || pm_busy;

	// rates saturate at the output width
	always_comb begin
		pps_sat  = (|pps_quo[DVD_W-1:OUT_W])  ? '1 : pps_quo[OUT_W-1:0];
		kbps_sat = (|kbps_quo[DVD_W-1:OUT_W]) ? '1 : kbps_quo[OUT_W-1:0];
	end

	// sequencer, monitor state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			next_seq_q  <= 16'd1;
			session_q   <= 1'b0;
			rx_total_q  <= '0;
			reorder_q   <= '0;
			bad_q       <= '0;
			win_start_q <= '0;
			win_rx_q    <= '0;
			win_loss_q  <= '0;
			last_us_q   <= '0;
			max_gap_q   <= '0;
			res_valid_q <= 1'b0;
			ev_q        <= EV_CHUNK;
			pps_q       <= '0;
			kbps_q      <= '0;
			lost_q      <= '0;
			pm_q        <= '0;
			gap_out_q   <= '0;
			rx_out_q    <= '0;
			reorder_out_q <= '0;
			bad_out_q   <= '0;
			idle_out_q  <= 1'b0;
		end else begin
			// output register fills on a finished item, empties on a result transfer
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (action_q && due) begin
						state_q <= S_DIV;
					end else if (out_free) begin
						state_q       <= S_IDLE;
						pps_q         <= '0;
						kbps_q        <= '0;
						lost_q        <= '0;
						pm_q          <= '0;
						gap_out_q     <= '0;
						rx_out_q      <= '0;
						reorder_out_q <= '0;
						bad_out_q     <= '0;
						idle_out_q    <= 1'b0;
						if (action_q) begin
							ev_q <= EV_NOT_DUE;
						end else if (is_begin) begin
							ev_q        <= EV_BEGIN;
							next_seq_q  <= 16'd1;
							session_q   <= 1'b1;
							rx_total_q  <= '0;
							reorder_q   <= '0;
							bad_q       <= '0;
							win_rx_q    <= '0;
							win_loss_q  <= '0;
							max_gap_q   <= '0;
							last_us_q   <= time_us_q;
							win_start_q <= time_ms_q;
						end else if (is_end) begin
							ev_q <= EV_END;
						end else if (is_chunk) begin
							ev_q        <= EV_CHUNK;
							session_q   <= 1'b1;
							win_start_q <= base_win_start;
							bad_q       <= base_bad;
							last_us_q   <= time_us_q;
							max_gap_q   <= (gap > base_max) ? gap : base_max;
							next_seq_q  <= seq_q + 16'd1;
							rx_total_q  <= base_rx_total + 1'b1;
							win_rx_q    <= base_win_rx + 1'b1;
							// small forward jump is loss, anything else nonzero a reorder
							if (jump != '0 && jump < LOSS_JUMP_LIMIT) begin
								win_loss_q <= base_win_loss + CNT_W'(jump);
								reorder_q  <= base_reorder;
							end else if (jump != '0) begin
								win_loss_q <= base_win_loss;
								reorder_q  <= base_reorder + 1'b1;
							end else begin
								win_loss_q <= base_win_loss;
								reorder_q  <= base_reorder;
							end
						end else begin
							ev_q  <= EV_BAD;
							bad_q <= bad_q + 1'b1;
						end
					end
				end
				S_DIV: begin
					if (!div_busy && out_free) begin
						state_q       <= S_IDLE;
						ev_q          <= EV_REPORT;
						pps_q         <= pps_sat;
						kbps_q        <= kbps_sat;
						lost_q        <= win_loss_q[OUT_W-1:0];
						pm_q          <= (offered == '0) ? '0 : pm_quo[9:0];
						gap_out_q     <= max_gap_q;
						rx_out_q      <= rx_total_q[OUT_W-1:0];
						reorder_out_q <= reorder_q[OUT_W-1:0];
						bad_out_q     <= bad_q[OUT_W-1:0];
						idle_out_q    <= session_q && (win_rx_q == '0);
						// open a new window
						win_start_q   <= time_ms_q;
						win_rx_q      <= '0;
						win_loss_q    <= '0;
						max_gap_q     <= '0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// channel outputs
	assign item.ready                = state_q == S_IDLE;
	assign result.valid              = res_valid_q;
	assign result.event_kind         = ev_q;
	assign result.packets_per_second = pps_q;
	assign result.payload_kbps       = kbps_q;
	assign result.window_lost        = lost_q;
	assign result.loss_per_mille     = pm_q;
	assign result.gap_max_us         = gap_out_q;
	assign result.received_total     = rx_out_q;
	assign result.reordered_total    = reorder_out_q;
	assign result.bad_total          = bad_out_q;
	assign result.nothing_arriving   = idle_out_q;

endmodule

FILE: test/packet_link_quality_monitor_tb.sv
// testbench: link quality monitor checked transfer by transfer against a scoreboard model
`timescale 1ns / 1ps

module packet_link_quality_monitor_tb;
	import plqm_pkg::*;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int PHASE_ITEMS   = 238;
	localparam int PHASES        = 8;

	typedef struct packed {
		logic        action;
		logic [7:0]  len;
		logic [7:0]  ver;
		logic [7:0]  typ;
		logic [15:0] seq;
		logic [31:0] us;
		logic [31:0] ms;
	} header_t;

	typedef struct packed {
		event_kind_t kind;
		logic [31:0] pps;
		logic [31:0] kbps;
		logic [31:0] lost;
		logic [9:0]  permille;
		logic [31:0] gap;
		logic [31:0] rx_total;
		logic [31:0] reorders;
		logic [31:0] bad;
		logic        nothing;
	} event_t;

	// link statistics model and the queue of events it predicts
	class link_quality_board;
		logic [7:0]  version_reg, begin_reg, end_reg, chunk_reg, bytes_reg;
		logic [15:0] period_reg;
		logic [15:0] next_seq;
		bit          in_session;
		logic [31:0] rx_total, reorders, bad_cnt, win_start_ms, win_rx, win_lost;
		logic [31:0] last_us, max_gap;
		event_t      expected_events[$];
		int          errors;
		int          kind_count[6];

		function new();
			version_reg = RST_VERSION;
			begin_reg = RST_BEGIN;
			end_reg = RST_END;
			chunk_reg = RST_CHUNK;
			bytes_reg = RST_MSG_BYTES;
			period_reg = RST_PERIOD;
			next_seq = 16'd1;
			in_session = 1'b0;
			rx_total = '0;
			reorders = '0;
			bad_cnt = '0;
			win_start_ms = '0;
			win_rx = '0;
			win_lost = '0;
			last_us = '0;
			max_gap = '0;
			errors = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [31:0] value);
			case (idx)
			REG_VERSION:   version_reg = value[7:0];
			REG_BEGIN:     begin_reg = value[7:0];
			REG_END:       end_reg = value[7:0];
			REG_CHUNK:     chunk_reg = value[7:0];
			REG_MSG_BYTES: bytes_reg = value[7:0];
			REG_PERIOD:    period_reg = value[15:0];
			default: ;
			endcase
		endfunction

		// session start clears all counters and anchors both clocks
		function void open_session(header_t h);
			next_seq = 16'd1;
			in_session = 1'b1;
			rx_total = '0;
			reorders = '0;
			bad_cnt = '0;
			win_rx = '0;
			win_lost = '0;
			max_gap = '0;
			last_us = h.us;
			win_start_ms = h.ms;
		endfunction

		// exact quotient saturated to 32 bits
		function logic [31:0] rate(logic [63:0] count, logic [63:0] factor, logic [31:0] elapsed);
			logic [63:0] q;
			q = count * factor / elapsed;
			return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
		endfunction

		// predict the event of one accepted transfer
		function void note_item(header_t h);
			event_t      r;
			logic [31:0] gap, elapsed, span;
			logic [15:0] jump;
			logic [63:0] offered;
			r = '0;
			r.kind = EV_CHUNK;
			if (!h.action) begin
				if (h.len != bytes_reg || h.ver != version_reg) begin
					bad_cnt++;
					r.kind = EV_BAD;
				end else if (h.typ == begin_reg) begin
					open_session(h);
					r.kind = EV_BEGIN;
				end else if (h.typ == end_reg) begin
					r.kind = EV_END;
				end else if (h.typ != chunk_reg) begin
					bad_cnt++;
					r.kind = EV_BAD;
				end else begin
					if (!in_session)
						open_session(h);
					gap = h.us - last_us;
					if (gap > max_gap)
						max_gap = gap;
					last_us = h.us;
					jump = h.seq - next_seq;
					if (jump != 0) begin
						if (jump < LOSS_JUMP_LIMIT)
							win_lost = win_lost + 32'(jump);
						else
							reorders++;
					end
					next_seq = h.seq + 16'd1;
					rx_total++;
					win_rx++;
				end
			end else begin
				elapsed = h.ms - win_start_ms;
				span = (period_reg == 0) ? 32'd1 : 32'(period_reg);
				if (elapsed < span) begin
					r.kind = EV_NOT_DUE;
				end else begin
					r.kind = EV_REPORT;
					r.pps = rate(64'(win_rx), 64'(RATE_SCALE), elapsed);
					r.kbps = rate(64'(win_rx), 64'(bytes_reg) * 8, elapsed);
					r.lost = win_lost;
					offered = 64'(win_rx) + 64'(win_lost);
					r.permille = (offered == 0) ? '0 : 10'(64'(win_lost) * RATE_SCALE / offered);
					r.gap = max_gap;
					r.rx_total = rx_total;
					r.reorders = reorders;
					r.bad = bad_cnt;
					r.nothing = in_session && win_rx == 0;
					win_start_ms = h.ms;
					win_rx = '0;
					win_lost = '0;
					max_gap = '0;
				end
			end
			expected_events.push_back(r);
		endfunction

		function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// check one result transfer against the oldest prediction
		function void check_event(event_t a);
			event_t e;
			if (expected_events.size() == 0) begin
				$error("result with nothing pending: event_kind %0d", a.kind);
				errors++;
				return;
			end
			e = expected_events.pop_front();
			compare("event_kind", 32'(e.kind), 32'(a.kind));
			compare("packets_per_second", e.pps, a.pps);
			compare("payload_kbps", e.kbps, a.kbps);
			compare("window_lost", e.lost, a.lost);
			compare("loss_per_mille", 32'(e.permille), 32'(a.permille));
			compare("gap_max_us", e.gap, a.gap);
			compare("received_total", e.rx_total, a.rx_total);
			compare("reordered_total", e.reorders, a.reorders);
			compare("bad_total", e.bad, a.bad);
			compare("nothing_arriving", 32'(e.nothing), 32'(a.nothing));
			kind_count[int'(e.kind)]++;
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	plqm_in_if  item_ch();
	plqm_out_if result_ch();

	link_quality_board board;
	event_t      seen;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_asks;
	int          hold_done;
	int          hold_left;
	int          settings_used;
	longint      cycles;
	logic [31:0] now_ms, now_us;
	logic [15:0] seq_next;

	packet_link_quality_monitor u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.item    (item_ch),
		.result  (result_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off when asked
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asks != hold_done) begin
			result_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= hold_asks;
		end else begin
			result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			seen.kind = event_kind_t'(result_ch.event_kind);
			seen.pps = result_ch.packets_per_second;
			seen.kbps = result_ch.payload_kbps;
			seen.lost = result_ch.window_lost;
			seen.permille = result_ch.loss_per_mille;
			seen.gap = result_ch.gap_max_us;
			seen.rx_total = result_ch.received_total;
			seen.reorders = result_ch.reordered_total;
			seen.bad = result_ch.bad_total;
			seen.nothing = result_ch.nothing_arriving;
			board.check_event(seen);
		end
	end

	function automatic header_t mk(logic action, logic [7:0] len, logic [7:0] ver,
			logic [7:0] typ, logic [15:0] seq, logic [31:0] us, logic [31:0] ms);
		header_t h;
		h.action = action;
		h.len = len;
		h.ver = ver;
		h.typ = typ;
		h.seq = seq;
		h.us = us;
		h.ms = ms;
		return h;
	endfunction

	// offer one item after an optional idle gap, note it on transfer
	task automatic send_item(header_t h);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.action <= h.action;
		item_ch.packet_length <= h.len;
		item_ch.version_byte <= h.ver;
		item_ch.message_type <= h.typ;
		item_ch.sequence_req <= h.seq;
		item_ch.time_us <= h.us;
		item_ch.time_ms <= h.ms;
		do
			@(posedge clk);
		while (item_ch.ready !== 1'b1);
		board.note_item(h);
	endtask

	// register write in setup and access cycles, then read back
	task automatic write_reg(reg_index_t idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(int'(idx) * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		board.compare($sformatf("register %s", idx.name()), value, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		board.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic apply_config(logic [7:0] ver, logic [7:0] begin_c, logic [7:0] end_c,
			logic [7:0] chunk_c, logic [7:0] bytes, logic [15:0] period);
		write_reg(REG_VERSION, 32'(ver));
		write_reg(REG_BEGIN, 32'(begin_c));
		write_reg(REG_END, 32'(end_c));
		write_reg(REG_CHUNK, 32'(chunk_c));
		write_reg(REG_MSG_BYTES, 32'(bytes));
		write_reg(REG_PERIOD, 32'(period));
		settings_used++;
	endtask

	// wait until every predicted event has come out, then let the block go quiet
	task automatic settle();
		while (board.expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly well-formed traffic with a running clock, some broken headers and noise
	task automatic random_item(output header_t h);
		int          roll;
		int          span;
		logic [15:0] delta;
		span = (board.period_reg < 8) ? 2 : int'(board.period_reg) / 4;
		if ($urandom_range(0, 199) == 0) begin
			now_ms = $urandom;
			now_us = $urandom;
		end
		now_ms += $urandom_range(0, span);
		now_us += $urandom_range(0, span * 1000);
		h = mk(1'b0, board.bytes_reg, board.version_reg, board.chunk_reg, seq_next,
			now_us, now_ms);
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			h.action = 1'($urandom);
			h.len = 8'($urandom);
			h.ver = 8'($urandom);
			h.typ = 8'($urandom);
			h.seq = 16'($urandom);
			h.us = $urandom;
			h.ms = $urandom;
		end else if (roll < 9) begin
			case ($urandom_range(0, 2))
			0: h.len = h.len + 8'($urandom_range(1, 255));
			1: h.ver = h.ver + 8'($urandom_range(1, 255));
			default: h.typ = 8'($urandom);
			endcase
		end else if (roll < 12) begin
			h.typ = board.begin_reg;
			h.seq = 16'($urandom);
			seq_next = 16'd1;
		end else if (roll < 14) begin
			h.typ = board.end_reg;
		end else if (roll < 30) begin
			h.action = 1'b1;
			h.seq = 16'($urandom);
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 8)
				delta = 16'($urandom_range(1, 999));
			else if (roll < 10)
				delta = 16'($urandom_range(1000, 65535));
			else if (roll < 12)
				delta = 16'hFFFF - 16'($urandom_range(0, 3));
			else
				delta = '0;
			h.seq = seq_next + delta;
			seq_next = h.seq + 16'd1;
		end
	endtask

	task automatic run_phase(int count, int idle_mode);
		header_t h;
		case (idle_mode)
		0: begin send_idle_pct = 0; recv_stall_pct = 0; end
		1: begin send_idle_pct = 48; recv_stall_pct = 0; end
		2: begin send_idle_pct = 0; recv_stall_pct = 48; end
		default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
		repeat (count) begin
			random_item(h);
			send_item(h);
		end
		item_ch.valid <= 1'b0;
		settle();
	endtask

	initial begin
		board = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.action <= 1'b0;
		item_ch.packet_length <= '0;
		item_ch.version_byte <= '0;
		item_ch.message_type <= '0;
		item_ch.sequence_req <= '0;
		item_ch.time_us <= '0;
		item_ch.time_ms <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on reset settings
		send_item(mk(1, 0, 0, 0, 0, 0, 0));
		send_item(mk(1, 0, 0, 0, 0, 0, 1000));
		// chunk with no session opens one, jump of four counts as loss
		send_item(mk(0, 224, 1, 2, 5, 1000, 1500));
		send_item(mk(0, 0, 1, 2, 6, 0, 0));
		send_item(mk(0, 255, 1, 2, 6, 0, 0));
		send_item(mk(0, 224, 0, 2, 6, 0, 0));
		send_item(mk(0, 224, 255, 2, 6, 0, 0));
		send_item(mk(0, 224, 1, 255, 6, 0, 0));
		send_item(mk(0, 224, 1, 2, 6, 6000, 1505));
		// largest loss jump, smallest reorder jump, one step back
		send_item(mk(0, 224, 1, 2, 1006, 9000, 1509));
		send_item(mk(0, 224, 1, 2, 2007, 9100, 1510));
		send_item(mk(0, 224, 1, 2, 2007, 9200, 1511));
		send_item(mk(0, 224, 1, 1, 0, 0, 0));
		send_item(mk(1, 0, 0, 0, 0, 0, 2499));
		send_item(mk(1, 0, 0, 0, 0, 0, 2500));
		send_item(mk(1, 0, 0, 0, 0, 0, 3500));
		// session begin just below the wrap of both clocks
		send_item(mk(0, 224, 1, 0, 77, 32'hFFFF_FF00, 32'hFFFF_FF00));
		send_item(mk(0, 224, 1, 2, 16'hFFFF, 32'hFFFF_FFF0, 32'hFFFF_FF10));
		send_item(mk(0, 224, 1, 2, 16'h0000, 32'h0000_0100, 32'hFFFF_FF20));
		send_item(mk(1, 0, 0, 0, 0, 0, 32'h0000_02E7));
		send_item(mk(1, 0, 0, 0, 0, 0, 32'h0000_02E8));
		send_item(mk(0, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, '1, '1));
		item_ch.valid <= 1'b0;
		settle();

		// zero report period behaves as one millisecond
		apply_config(1, 0, 1, 2, 224, 0);
		send_item(mk(1, 0, 0, 0, 0, 0, 32'h0000_02E8));
		send_item(mk(1, 0, 0, 0, 0, 0, 32'h0000_02E9));
		item_ch.valid <= 1'b0;
		settle();

		// random phases over several settings and idling patterns
		for (int i = 0; i < PHASES; i++) begin
			case (i)
			0: apply_config(1, 0, 1, 2, 224, 1000);
			1: apply_config(255, 255, 0, 128, 255, 65535);
			2: apply_config(0, 7, 9, 200, 1, 1);
			4: apply_config(3, 5, 5, 6, 64, 250);
			5: apply_config(1, 0, 1, 2, 224, 1000);
			7: apply_config(200, 17, 34, 51, 128, 30000);
			default: apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(1, 255)), 16'($urandom_range(1, 5000)));
			endcase
			// long output hold-off while the sender keeps offering
			if (i == 4)
				hold_asks++;
			now_ms = $urandom;
			now_us = $urandom;
			seq_next = 16'($urandom);
			run_phase(PHASE_ITEMS, i % 4);
		end

		$display("summary: %0d results checked over %0d register settings, four idling patterns",
			board.kind_count.sum(), settings_used);
		$display("events: chunk %0d, bad %0d, begin %0d, end %0d, not due %0d, report %0d",
			board.kind_count[EV_CHUNK], board.kind_count[EV_BAD], board.kind_count[EV_BEGIN],
			board.kind_count[EV_END], board.kind_count[EV_NOT_DUE], board.kind_count[EV_REPORT]);
		if (board.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
